### rtl/kls_pkg.sv
// Package: shared constants and types of the k-th largest selector.
`timescale 1ns / 1ps
`default_nettype none

package kls_pkg;

    // Chain depth and field widths
    localparam int MAX_RANK = 64;
    localparam int DATA_W   = 32;
    localparam int RANK_W   = 7;
    localparam int CNT_W    = $clog2(MAX_RANK + 1);
    localparam int KW       = (RANK_W > CNT_W) ? RANK_W : CNT_W;

    // Configuration port
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;
    localparam logic REG_K_RANK = 1'b0;

    // Broadcast control from the top level to every cell
    typedef struct packed {
        logic                     load;
        logic signed [DATA_W-1:0] sample;
    } t_cell_ctl;

    // Values of all cells side by side
    typedef logic [MAX_RANK-1:0][DATA_W-1:0] t_val_row;

endpackage

`default_nettype wire

### rtl/kls_if.sv
// Interfaces: sample input channel and result output channel.
`timescale 1ns / 1ps
`default_nettype none

interface kls_smp_if;
    import kls_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] sample_value;
    logic                     last_of_set;

    modport source (output valid, output sample_value, output last_of_set, input ready);
    modport sink   (input valid, input sample_value, input last_of_set, output ready);
endinterface

interface kls_res_if;
    import kls_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] kth_value;
    logic                     short_set;

    modport source (output valid, output kth_value, output short_set, input ready);
    modport sink   (input valid, input kth_value, input short_set, output ready);
endinterface

`default_nettype wire

### rtl/kls_cell.sv
// One cell of the sorted insertion chain: holds a value, inserts or shifts.
`timescale 1ns / 1ps
`default_nettype none

module kls_cell (
    input  wire                                i_clk,
    input  kls_pkg::t_cell_ctl                 i_ctl,
    input  wire                                i_kept,
    input  wire        [kls_pkg::DATA_W-1:0]   i_left_val,
    input  wire                                i_left_ge,
    output logic       [kls_pkg::DATA_W-1:0]   o_val,
    output logic                               o_ge
);
    import kls_pkg::*;

    logic [DATA_W-1:0] r_val;
    logic [DATA_W-1:0] n_val;

    // Kept value at or above the sample stays in place
    assign o_ge = i_kept && ($signed(r_val) >= i_ctl.sample);
    assign o_val = r_val;

    // Keep, take the sample at the insertion point, or shift from the left
    always_comb begin
        if (o_ge) begin
            n_val = r_val;
        end else if (i_left_ge) begin
            n_val = i_ctl.sample;
        end else begin
            n_val = i_left_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_val <= n_val;
        end
    end

endmodule

`default_nettype wire

### rtl/kls_pick.sv
// Tail select: AND-OR pick of the one cell named by a one-hot select.
`timescale 1ns / 1ps
`default_nettype none

module kls_pick (
    input  kls_pkg::t_val_row                  i_vals,
    input  wire        [kls_pkg::MAX_RANK-1:0] i_sel,
    output logic       [kls_pkg::DATA_W-1:0]   o_val
);
    import kls_pkg::*;

    // Merge the selected word
    always_comb begin
        o_val = '0;
        for (int i = 0; i < MAX_RANK; i++) begin
            o_val = o_val | (i_vals[i] & {DATA_W{i_sel[i]}});
        end
    end

endmodule

`default_nettype wire

### rtl/kth_largest_selector_unit.sv
// Top level: streaming k-th largest selector built on a sorted insertion chain.
//
//  channel   | dir | payload                         | transfer
//  ----------+-----+---------------------------------+---------------------
//  i_smp     | in  | sample_value[31:0], last_of_set | valid && ready
//  o_res     | out | kth_value[31:0], short_set      | valid && ready
//  APB       | in  | k_rank at byte address 0        | psel&penable&pwrite
//
//  One sample per cycle while no pick is pending: every cell compares against the
//  broadcast sample in the same cycle and takes its left neighbor's value on a shift.
//  After a last_of_set sample the input holds off while the tail cell is picked:
//  the tail select is registered, then the picked value moves into the output register.
//  Reset clears the kept count, the pending result and sets k_rank to 1.
//  The output register holds a result under stall; the input stalls while a
//  picked result waits to move into it.
`timescale 1ns / 1ps
`default_nettype none

module kth_largest_selector_unit (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    kls_smp_if.sink                            i_smp,
    kls_res_if.source                          o_res,
    input  wire                                psel,
    input  wire                                penable,
    input  wire                                pwrite,
    input  wire        [kls_pkg::APB_AW-1:0]   paddr,
    input  wire        [kls_pkg::APB_DW-1:0]   pwdata,
    output logic       [kls_pkg::APB_DW-1:0]   prdata,
    output logic                               pready
);
    import kls_pkg::*;

    logic [RANK_W-1:0]   r_k_rank;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;
    logic                r_pend;
    logic                r_pend_short;
    logic [MAX_RANK-1:0] r_sel;
    logic                r_ovalid;
    logic [DATA_W-1:0]   r_okth;
    logic                r_oshort;

    logic [KW-1:0]       k_wide;
    logic [CNT_W-1:0]    k_eff;
    logic [CNT_W-1:0]    cnt_eff;
    logic [CNT_W-1:0]    cnt_new;
    logic                accept;
    logic                move_out;
    t_cell_ctl           cell_ctl;
    t_val_row            vals;
    logic [MAX_RANK-1:0] kept;
    logic [MAX_RANK-1:0] ge;
    logic [MAX_RANK-1:0] sel_new;
    logic [DATA_W-1:0]   pick_val;

    // Configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_K_RANK) ? APB_DW'(r_k_rank) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_rank <= RANK_W'(1);
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_K_RANK)) begin
            r_k_rank <= pwdata[RANK_W-1:0];
        end
    end

    // Clamp the rank into 1..MAX_RANK
    assign k_wide = KW'(r_k_rank);
    always_comb begin
        if (k_wide == '0) begin
            k_eff = CNT_W'(1);
        end else if (k_wide > KW'(MAX_RANK)) begin
            k_eff = CNT_W'(MAX_RANK);
        end else begin
            k_eff = k_wide[CNT_W-1:0];
        end
    end

    // Drop kept values beyond a lowered rank
    assign cnt_eff = (r_count > k_eff) ? k_eff : r_count;

    // Input handshake
    assign i_smp.ready   = !r_pend;
    assign accept        = i_smp.valid && i_smp.ready;
    assign cell_ctl.load   = accept;
    assign cell_ctl.sample = i_smp.sample_value;

    // Insertion chain
    for (genvar g = 0; g < MAX_RANK; g++) begin : g_cell
        assign kept[g] = CNT_W'(g) < cnt_eff;
        if (g == 0) begin : g_head
            kls_cell u_cell (
                .i_clk      (i_clk),
                .i_ctl      (cell_ctl),
                .i_kept     (kept[g]),
                .i_left_val ({DATA_W{1'b0}}),
                .i_left_ge  (1'b1),
                .o_val      (vals[g]),
                .o_ge       (ge[g])
            );
        end else begin : g_body
            kls_cell u_cell (
                .i_clk      (i_clk),
                .i_ctl      (cell_ctl),
                .i_kept     (kept[g]),
                .i_left_val (vals[g-1]),
                .i_left_ge  (ge[g-1]),
                .o_val      (vals[g]),
                .o_ge       (ge[g])
            );
        end
        assign sel_new[g] = CNT_W'(g + 1) == cnt_new;
    end

    // Count after the insert: grows until the chain holds k values, then the smallest drops
    assign cnt_new = (cnt_eff < k_eff) ? cnt_eff + CNT_W'(1) : cnt_eff;
    assign n_count = i_smp.last_of_set ? '0 : cnt_new;

    kls_pick u_pick (
        .i_vals (vals),
        .i_sel  (r_sel),
        .o_val  (pick_val)
    );

    assign move_out = r_pend && (!r_ovalid || o_res.ready);

    // Count, pending pick and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (accept) begin
                r_count <= n_count;
            end
            if (accept && i_smp.last_of_set) begin
                r_pend <= 1'b1;
            end else if (move_out) begin
                r_pend <= 1'b0;
            end
            if (move_out) begin
                r_ovalid <= 1'b1;
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_smp.last_of_set) begin
            r_sel        <= sel_new;
            r_pend_short <= cnt_new < k_eff;
        end
        if (move_out) begin
            r_okth   <= pick_val;
            r_oshort <= r_pend_short;
        end
    end

    assign o_res.valid     = r_ovalid;
    assign o_res.kth_value = r_okth;
    assign o_res.short_set = r_oshort;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_RANK))
        else $error("kept count exceeds chain depth");

    a_last_pends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_smp.last_of_set) |=> (r_pend && $onehot(r_sel)))
        else $error("last sample did not leave a single tail select");

    a_head_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= CNT_W'(2)) |-> ($signed(vals[0]) >= $signed(vals[1])))
        else $error("chain head out of order");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend && r_ovalid && !o_res.ready) |=> (r_pend && r_ovalid))
        else $error("pending result lost under stall");
`endif

endmodule

`default_nettype wire

### dv/kth_largest_selector_unit_tb.sv
// Testbench: drives sample sets and rank writes, checks every k-th largest result.
`timescale 1ns / 1ps

module kth_largest_selector_unit_tb;
    import kls_pkg::*;

    localparam int SET_LATENCY = 4;     // idle margin after the last result before a rank write
    localparam int STALL_LIMIT = 5000;  // cycles with no transfer before the run gives up
    localparam int TOTAL_ITEMS = 1800;
    localparam logic [APB_AW-1:0] RANK_ADDR = APB_AW'(4 * int'(REG_K_RANK));

    typedef enum logic {ROW_SAMPLE, ROW_RANK} t_row_kind;
    typedef enum logic [1:0] {RDY_ALWAYS, RDY_HALF, RDY_RARE, RDY_BLOCKED} t_ready_mode;

    // One directed step: a sample (with an optional typed-in result) or a rank write
    typedef struct packed {
        t_row_kind   kind;
        logic [31:0] data;
        logic        last;
        logic        typed;
        logic [31:0] exp_kth;
        logic        exp_under;
    } t_dir_row;

    typedef struct packed {
        logic signed [DATA_W-1:0] kth;
        logic                     under;
    } t_kth_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    kls_smp_if smp();
    kls_res_if res();

    kth_largest_selector_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_smp   (smp),
        .o_res   (res),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predictor state: kept values from largest to smallest, and the rank register
    logic signed [DATA_W-1:0] chain_vals [MAX_RANK];
    int unsigned              chain_cnt;
    logic [RANK_W-1:0]        rank_reg;
    t_kth_result              kth_expected [$];
    t_kth_result              kth_want;

    int unsigned err_cnt;
    int unsigned quiet_cycles;
    int unsigned samples_sent;
    int unsigned burst_left;
    int unsigned stall_left;
    t_ready_mode stall_mode;

    t_dir_row dir_rows [29] = '{
        // rank 1 after reset: extremes alone and together
        '{ROW_SAMPLE, 32'h7FFF_FFFF, 1'b1, 1'b1, 32'h7FFF_FFFF, 1'b0},
        '{ROW_SAMPLE, 32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000, 1'b0},
        '{ROW_SAMPLE, 32'h0000_0005, 1'b0, 1'b0, 32'h0,         1'b0},
        '{ROW_SAMPLE, 32'h8000_0000, 1'b0, 1'b0, 32'h0,         1'b0},
        '{ROW_SAMPLE, 32'h7FFF_FFFF, 1'b1, 1'b1, 32'h7FFF_FFFF, 1'b0},
        // rank zero behaves as rank one
        '{ROW_RANK,   32'h0000_0000, 1'b0, 1'b0, 32'h0,         1'b0},
        '{ROW_SAMPLE, 32'hFFFF_FFFD, 1'b0, 1'b0, 32'h0,         1'b0},
        '{ROW_SAMPLE, 32'h0000_0007, 1'b0, 1'b0, 32'h0,         1'b0},
        '{ROW_SAMPLE, 32'h0000_0002, 1'b1, 1'b1, 32'h0000_0007, 1'b0},
        // rank 3: ties, short sets, sign handling
        '{ROW_RANK,   32'h0000_0003, 1'b0, 1'b0, 32'h0,         1'b0},
        '{ROW_SAMPLE, 32'h000A_0000, 1'b0, 1'b0, 32'h0,         1'b0},
        '{ROW_SAMPLE, 32'h000A_0000, 1'b0, 1'b0, 32'h0,         1'b0},
        '{ROW_SAMPLE, 32'h000A_0000, 1'b1, 1'b1, 32'h000A_0000, 1'b0},
        '{ROW_SAMPLE, 32'h0000_0001, 1'b1, 1'b1, 32'h0000_0001, 1'b1},
        '{ROW_SAMPLE, 32'h0000_0004, 1'b0, 1'b0, 32'h0,         1'b0},
        '{ROW_SAMPLE, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1},
        '{ROW_SAMPLE, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0,         1'b0},
        '{ROW_SAMPLE, 32'h0000_0001, 1'b0, 1'b0, 32'h0,         1'b0},
        '{ROW_SAMPLE, 32'h8000_0000, 1'b0, 1'b0, 32'h0,         1'b0},
        '{ROW_SAMPLE, 32'h7FFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0},
        // rank field all ones saturates at the chain depth; upper data bits set
        '{ROW_RANK,   32'hFFFF_FF7F, 1'b0, 1'b0, 32'h0,         1'b0},
        '{ROW_SAMPLE, 32'h0000_0009, 1'b0, 1'b0, 32'h0,         1'b0},
        '{ROW_SAMPLE, 32'h0000_0008, 1'b1, 1'b1, 32'h0000_0008, 1'b1},
        // shrink the rank in the middle of a set
        '{ROW_RANK,   32'h0000_0004, 1'b0, 1'b0, 32'h0,         1'b0},
        '{ROW_SAMPLE, 32'h0000_0028, 1'b0, 1'b0, 32'h0,         1'b0},
        '{ROW_SAMPLE, 32'h0000_001E, 1'b0, 1'b0, 32'h0,         1'b0},
        '{ROW_SAMPLE, 32'h0000_0014, 1'b0, 1'b0, 32'h0,         1'b0},
        '{ROW_SAMPLE, 32'h0000_000A, 1'b0, 1'b0, 32'h0,         1'b0},
        '{ROW_RANK,   32'h0000_0002, 1'b0, 1'b0, 32'h0,         1'b0}
    };

    // Clock
    always #1 i_clk = ~i_clk;

    // Rank in force: zero acts as one, anything past the chain depth is clipped
    function automatic int unsigned rank_in_force();
        int unsigned k;
        k = rank_reg;
        if (k == 0) k = 1;
        if (k > MAX_RANK) k = MAX_RANK;
        return k;
    endfunction

    // Insert one sample into the sorted chain; on the last of a set, select and clear
    function automatic bit chain_insert(input logic signed [DATA_W-1:0] v, input logic last,
                                        output t_kth_result r);
        int unsigned k;
        int unsigned pos;
        int unsigned top;
        k = rank_in_force();
        r = '0;
        if (chain_cnt > k) chain_cnt = k;
        pos = 0;
        while (pos < chain_cnt && chain_vals[pos] >= v) pos++;
        if (pos < k) begin
            top = (chain_cnt < k) ? chain_cnt : k - 1;
            for (int unsigned i = top; i > pos; i--) chain_vals[i] = chain_vals[i - 1];
            chain_vals[pos] = v;
            if (chain_cnt < k) chain_cnt++;
        end
        if (!last) return 1'b0;
        if (chain_cnt >= k) begin
            r.kth   = chain_vals[k - 1];
            r.under = 1'b0;
        end else begin
            r.kth   = chain_vals[chain_cnt - 1];
            r.under = 1'b1;
        end
        chain_cnt = 0;
        return 1'b1;
    endfunction

    // Send one sample in bursts with random gaps; predict once it transfers
    task automatic send_sample(input logic signed [DATA_W-1:0] v, input logic last,
                               input logic typed, input t_kth_result typed_res);
        int unsigned gap;
        t_kth_result r;
        @(negedge i_clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                smp.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        smp.valid        <= 1'b1;
        smp.sample_value <= v;
        smp.last_of_set  <= last;
        do @(posedge i_clk); while (!smp.ready);
        if (chain_insert(v, last, r)) begin
            if (typed)
                kth_expected = {kth_expected, typed_res};
            else
                kth_expected = {kth_expected, r};
        end
        samples_sent++;
    endtask

    // Drop valid, wait out every pending result and the block's own latency
    task automatic quiesce();
        @(negedge i_clk);
        smp.valid <= 1'b0;
        burst_left = 0;
        while (kth_expected.size() != 0) @(posedge i_clk);
        repeat (SET_LATENCY) @(posedge i_clk);
    endtask

    // Setup and access phases of one register transfer
    task automatic apb_access(input logic wr, input logic [APB_DW-1:0] wdata);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= RANK_ADDR;
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
    endtask

    // Write the rank while idle, then read it back
    task automatic write_rank(input logic [APB_DW-1:0] wdata);
        quiesce();
        apb_access(1'b1, wdata);
        rank_reg = wdata[RANK_W-1:0];
        apb_access(1'b0, '0);
        if (prdata[RANK_W-1:0] !== rank_reg) begin
            $display("%0t: k_rank readback expected %0d got %0d",
                     $time, rank_reg, prdata[RANK_W-1:0]);
            err_cnt++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Rank for a phase: mostly small, with the extremes and out-of-range codes mixed in
    function automatic logic [APB_DW-1:0] pick_rank();
        logic [APB_DW-1:0] w;
        w = $urandom();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: w[RANK_W-1:0] = RANK_W'($urandom_range(1, 8));
            5:             w[RANK_W-1:0] = '0;
            6:             w[RANK_W-1:0] = RANK_W'(MAX_RANK);
            7:             w[RANK_W-1:0] = RANK_W'($urandom_range(MAX_RANK - 1, MAX_RANK + 1));
            8:             w[RANK_W-1:0] = RANK_W'($urandom_range(MAX_RANK + 1, 127));
            default:       w[RANK_W-1:0] = RANK_W'($urandom_range(9, MAX_RANK));
        endcase
        return w;
    endfunction

    // Sample values: full range, a narrow pool for ties, and the extremes
    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 3))
            1:       return $signed(32'($urandom_range(0, 6)) - 32'd3);
            2: begin
                case ($urandom_range(0, 4))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7FFF_FFFF;
                    2:       return 32'h0000_0000;
                    3:       return 32'hFFFF_FFFF;
                    default: return 32'h0000_0001;
                endcase
            end
            default: return $urandom();
        endcase
    endfunction

    // Set length: often around k so short sets and full chains both occur
    function automatic int unsigned pick_set_len();
        int unsigned k;
        k = rank_in_force();
        if ($urandom_range(0, 2) == 0) return $urandom_range(k, 2 * k + 8);
        return $urandom_range(1, k + 4);
    endfunction

    // Receiver: stall pattern changes every stretch
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = t_ready_mode'($urandom_range(0, 3));
            stall_left = $urandom_range(8, 80);
        end
        stall_left--;
        case (stall_mode)
            RDY_ALWAYS:  res.ready <= 1'b1;
            RDY_HALF:    res.ready <= 1'($urandom_range(0, 1));
            RDY_RARE:    res.ready <= ($urandom_range(0, 3) == 0);
            default:     res.ready <= 1'b0;
        endcase
    end

    // Compare each result transfer with the oldest expected one
    always @(posedge i_clk) begin
        if (i_rst_n && res.valid && res.ready) begin
            if (kth_expected.size() == 0) begin
                $display("%0t: unexpected result kth_value=%h short_set=%b",
                         $time, res.kth_value, res.short_set);
                err_cnt++;
            end else begin
                kth_want = kth_expected.pop_front();
                if (res.kth_value !== kth_want.kth) begin
                    $display("%0t: kth_value expected %h got %h",
                             $time, kth_want.kth, res.kth_value);
                    err_cnt++;
                end
                if (res.short_set !== kth_want.under) begin
                    $display("%0t: short_set expected %b got %b",
                             $time, kth_want.under, res.short_set);
                    err_cnt++;
                end
            end
        end
    end

    // Watchdog: end the run after too long without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (smp.valid && smp.ready) || (res.valid && res.ready) || (psel && penable))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Stimulus
    initial begin
        int unsigned sets;
        int unsigned len;
        i_rst_n          = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        smp.valid        = 1'b0;
        smp.sample_value = '0;
        smp.last_of_set  = 1'b0;
        res.ready        = 1'b0;
        chain_cnt        = 0;
        rank_reg         = RANK_W'(1);
        err_cnt          = 0;
        quiet_cycles     = 0;
        samples_sent     = 0;
        burst_left       = 0;
        stall_left       = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table
        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_RANK)
                write_rank(dir_rows[i].data);
            else
                send_sample(dir_rows[i].data, dir_rows[i].last, dir_rows[i].typed,
                            '{kth: dir_rows[i].exp_kth, under: dir_rows[i].exp_under});
        end

        // Random phases, each under its own rank
        while (samples_sent < TOTAL_ITEMS) begin
            write_rank(pick_rank());
            sets = $urandom_range(2, 8);
            repeat (sets) begin
                if (samples_sent >= TOTAL_ITEMS) break;
                len = pick_set_len();
                for (int unsigned n = 1; n <= len; n++)
                    send_sample(pick_value(), n == len, 1'b0, '0);
            end
            // leave a set open so the next rank write lands mid-set
            if ($urandom_range(0, 3) == 0) begin
                len = $urandom_range(1, rank_in_force() + 2);
                repeat (len) send_sample(pick_value(), 1'b0, 1'b0, '0);
            end
        end

        // Close any open set, then drain
        send_sample(pick_value(), 1'b1, 1'b0, '0);
        quiesce();
        repeat (8) @(posedge i_clk);
        if (err_cnt == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
